// ===== design/stc_pkg.sv =====
// Package for the scan trigger counter: widths, codes and the
// command/status structs shared by the controller and datapath.
// No dependencies.
`default_nettype none

package stc_pkg;

  // Default parameter values
  localparam int COUNT_WIDTH_DEF = 16;
  localparam int PULSE_WIDTH_DEF = 24;

  // Fixed field widths
  localparam int TIME_W  = 32;
  localparam int BYTE_W  = 8;
  localparam int LEN_W   = 16;
  localparam int OUTC_W  = 16;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  // Divider width: elapsed time times slices plus rounding term
  localparam int DIVW    = TIME_W + BYTE_W + 1;
  localparam int DCNT_W  = $clog2(DIVW);

  // Pulse debounce window in ms
  localparam int DEBOUNCE_MS = 50;

  // Trigger modes
  localparam logic [1:0] MODE_SIM   = 2'd0;
  localparam logic [1:0] MODE_SLICE = 2'd1;
  localparam logic [1:0] MODE_CHAR  = 2'd2;
  localparam logic [1:0] MODE_PULSE = 2'd3;

  // Register indexes
  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_TRIG   = 2'd1;
  localparam logic [1:0] REG_SLICES = 2'd2;
  localparam logic [1:0] REG_TRLEN  = 2'd3;

  // Register reset values
  localparam logic [1:0]        MODE_RST   = MODE_SIM;
  localparam logic [BYTE_W-1:0] TRIG_RST   = 8'd84;
  localparam logic [BYTE_W-1:0] SLICES_RST = 8'd1;
  localparam logic [LEN_W-1:0]  TRLEN_RST  = 16'd2700;

  typedef struct packed {
    logic [1:0]        mode;
    logic [BYTE_W-1:0] trigger_char;
    logic [BYTE_W-1:0] slices_per_tr;
    logic [LEN_W-1:0]  tr_length_ms;
  } cfg_t;

  // Operand selection for the shared divider
  typedef enum logic [1:0] {
    DIV_SL = 2'd0,
    DIV_TR = 2'd1,
    DIV_M1 = 2'd2
  } div_sel_t;

  typedef struct packed {
    logic     start;
    logic     simple;
    logic     m0_prep;
    logic     m0_e;
    logic     div_go;
    div_sel_t div_sel;
    logic     latch_sl;
    logic     m0_commit;
    logic     m0_org;
    logic     m1_commit;
    logic     write_out;
  } cmd_t;

  typedef struct packed {
    logic       op;
    logic       counting;
    logic [1:0] mode;
    logic       bv;
    logic       hb_wait;
    logic       div_done;
    logic       out_free;
  } status_t;

endpackage

`default_nettype wire

// ===== design/stc_if.sv =====
// Channel interfaces for input items and result items.
// Depends on stc_pkg.
`default_nettype none

interface stc_item_if #(
  parameter int PULSE_WIDTH = stc_pkg::PULSE_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic                          operation;
  logic [stc_pkg::TIME_W-1:0]    now_ms;
  logic                          byte_valid;
  logic [stc_pkg::BYTE_W-1:0]    rx_byte;
  logic [PULSE_WIDTH-1:0]        pulse_count;

  modport source (output valid, operation, now_ms, byte_valid, rx_byte, pulse_count,
                  input ready);
  modport sink (input valid, operation, now_ms, byte_valid, rx_byte, pulse_count,
                output ready);
endinterface

interface stc_result_if;
  logic                        valid;
  logic                        ready;
  logic [stc_pkg::OUTC_W-1:0]  tr_number;
  logic [stc_pkg::OUTC_W-1:0]  slice_number;
  logic [stc_pkg::TIME_W-1:0]  tr_start_time;
  logic [stc_pkg::TIME_W-1:0]  scan_start_time;
  logic                        is_counting;

  modport source (output valid, tr_number, slice_number, tr_start_time,
                  scan_start_time, is_counting, input ready);
  modport sink (input valid, tr_number, slice_number, tr_start_time,
                scan_start_time, is_counting, output ready);
endinterface

`default_nettype wire

// ===== design/stc_cfg.sv =====
// Configuration register file behind the APB-style port.
// Depends on stc_pkg.
`default_nettype none

module stc_cfg (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [stc_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [stc_pkg::DATA_W-1:0]   pwdata,
  output logic      [stc_pkg::DATA_W-1:0]   prdata,
  output logic                              pready,
  output stc_pkg::cfg_t                     cfg
);

  logic [1:0] idx;

  assign idx    = paddr[3:2];
  assign pready = 1'b1;

  // Write registers on the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode          <= stc_pkg::MODE_RST;
      cfg.trigger_char  <= stc_pkg::TRIG_RST;
      cfg.slices_per_tr <= stc_pkg::SLICES_RST;
      cfg.tr_length_ms  <= stc_pkg::TRLEN_RST;
    end else if (psel && penable && pwrite) begin
      case (idx)
        stc_pkg::REG_MODE:   cfg.mode          <= pwdata[1:0];
        stc_pkg::REG_TRIG:   cfg.trigger_char  <= pwdata[7:0];
        stc_pkg::REG_SLICES: cfg.slices_per_tr <= pwdata[7:0];
        stc_pkg::REG_TRLEN:  cfg.tr_length_ms  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (idx)
      stc_pkg::REG_MODE:   prdata = 32'(cfg.mode);
      stc_pkg::REG_TRIG:   prdata = 32'(cfg.trigger_char);
      stc_pkg::REG_SLICES: prdata = 32'(cfg.slices_per_tr);
      stc_pkg::REG_TRLEN:  prdata = 32'(cfg.tr_length_ms);
      default:             prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== design/stc_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on stc_pkg.
`default_nettype none

module stc_div (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         go,
  input  wire logic [stc_pkg::DIVW-1:0]     dividend,
  input  wire logic [stc_pkg::LEN_W-1:0]    divisor,
  output logic      [stc_pkg::DIVW-1:0]     quotient,
  output logic      [stc_pkg::LEN_W-1:0]    remainder,
  output logic                              done
);

  logic                           busy;
  logic [stc_pkg::DCNT_W-1:0]     cnt;
  logic [stc_pkg::LEN_W-1:0]      dvs;
  logic [stc_pkg::LEN_W:0]        trial;
  logic                           fits;

  assign trial = {remainder, quotient[stc_pkg::DIVW-1]};
  assign fits  = trial >= {1'b0, dvs};

  // Control: run DIVW steps, pulse done
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == stc_pkg::DCNT_W'(stc_pkg::DIVW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Shift and subtract
  always_ff @(posedge clk) begin
    if (go) begin
      quotient  <= dividend;
      remainder <= '0;
      dvs       <= divisor;
    end else if (busy) begin
      quotient  <= {quotient[stc_pkg::DIVW-2:0], fits};
      remainder <= fits ? stc_pkg::LEN_W'(trial - {1'b0, dvs})
                        : trial[stc_pkg::LEN_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== design/stc_dp.sv =====
// Datapath: item capture, counters, origins, divider operands and the
// result register. Depends on stc_pkg and stc_div.
`default_nettype none

module stc_dp #(
  parameter int COUNT_WIDTH = stc_pkg::COUNT_WIDTH_DEF,
  parameter int PULSE_WIDTH = stc_pkg::PULSE_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  stc_pkg::cfg_t                      cfg,
  input  wire logic                          accept,
  input  wire logic                          operation,
  input  wire logic [stc_pkg::TIME_W-1:0]    now_ms,
  input  wire logic                          byte_valid,
  input  wire logic [stc_pkg::BYTE_W-1:0]    rx_byte,
  input  wire logic [PULSE_WIDTH-1:0]        pulse_count,
  input  stc_pkg::cmd_t                      cmd,
  output stc_pkg::status_t                   status,
  output logic                               res_valid,
  input  wire logic                          res_ready,
  output logic      [stc_pkg::OUTC_W-1:0]    tr_number,
  output logic      [stc_pkg::OUTC_W-1:0]    slice_number,
  output logic      [stc_pkg::TIME_W-1:0]    tr_start_time,
  output logic      [stc_pkg::TIME_W-1:0]    scan_start_time,
  output logic                               is_counting
);

  localparam int DIVW = stc_pkg::DIVW;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  function automatic logic [COUNT_WIDTH-1:0] sat_cnt(input logic [DIVW-1:0] v);
    logic [COUNT_WIDTH-1:0] r;
    if (|(v >> COUNT_WIDTH)) r = COUNT_MAX;
    else                     r = v[COUNT_WIDTH-1:0];
    return r;
  endfunction

  // Captured item
  logic                          itm_op;
  logic [stc_pkg::TIME_W-1:0]    itm_now;
  logic                          itm_bv;
  logic [stc_pkg::BYTE_W-1:0]    itm_byte;
  logic [PULSE_WIDTH-1:0]        itm_pulse;

  // Block state
  logic [COUNT_WIDTH-1:0]        tr_count;
  logic [COUNT_WIDTH-1:0]        slice_count;
  logic [stc_pkg::TIME_W-1:0]    scan_origin;
  logic [stc_pkg::TIME_W-1:0]    tr_origin;
  logic [PULSE_WIDTH-1:0]        last_pulse;
  logic [stc_pkg::BYTE_W-1:0]    held_byte;
  logic                          hb_wait;
  logic                          counting;

  // Working registers
  logic [stc_pkg::TIME_W-1:0]    elapsed;
  logic [COUNT_WIDTH-1:0]        sl_sat;
  logic [stc_pkg::TIME_W-1:0]    prod;

  // Divider
  logic [DIVW-1:0]               div_a;
  logic [stc_pkg::LEN_W-1:0]     div_b;
  logic [DIVW-1:0]               quo;
  logic [stc_pkg::LEN_W-1:0]     rem;
  logic                          div_done;

  logic [stc_pkg::LEN_W-1:0]     s_eff;
  logic [stc_pkg::LEN_W-1:0]     len_eff;
  logic [stc_pkg::LEN_W-1:0]     pair;
  logic [COUNT_WIDTH-1:0]        tr_inc;
  logic [COUNT_WIDTH-1:0]        tr_simple;
  logic                          trig_simple;
  logic [COUNT_WIDTH-1:0]        tr_m1;
  logic [stc_pkg::TIME_W-1:0]    since_tr;

  assign s_eff   = (cfg.slices_per_tr == '0) ? stc_pkg::LEN_W'(1)
                                             : stc_pkg::LEN_W'(cfg.slices_per_tr);
  assign len_eff = (cfg.tr_length_ms == '0) ? stc_pkg::LEN_W'(1) : cfg.tr_length_ms;
  assign pair    = {held_byte, itm_byte};
  assign tr_inc  = (tr_count == COUNT_MAX) ? COUNT_MAX : tr_count + 1'b1;
  assign since_tr = itm_now - tr_origin;

  // Divider operands
  always_comb begin
    case (cmd.div_sel)
      stc_pkg::DIV_SL: begin
        div_a = DIVW'(elapsed) * DIVW'(s_eff) + DIVW'(len_eff) - DIVW'(1);
        div_b = len_eff;
      end
      stc_pkg::DIV_TR: begin
        div_a = DIVW'(elapsed) + DIVW'(len_eff) - DIVW'(1);
        div_b = len_eff;
      end
      stc_pkg::DIV_M1: begin
        div_a = DIVW'(pair - stc_pkg::LEN_W'(1));
        div_b = s_eff;
      end
      default: begin
        div_a = '0;
        div_b = len_eff;
      end
    endcase
  end

  stc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .go        (cmd.div_go),
    .dividend  (div_a),
    .divisor   (div_b),
    .quotient  (quo),
    .remainder (rem),
    .done      (div_done)
  );

  // Trigger decision for modes without a division
  always_comb begin
    trig_simple = 1'b0;
    case (cfg.mode)
      stc_pkg::MODE_CHAR:
        trig_simple = itm_bv && (itm_byte == cfg.trigger_char);
      stc_pkg::MODE_PULSE:
        trig_simple = (itm_pulse != last_pulse) &&
                      ((tr_count == '0) ||
                       (since_tr > stc_pkg::TIME_W'(stc_pkg::DEBOUNCE_MS)));
      default:
        trig_simple = 1'b0;
    endcase
    tr_simple = trig_simple ? tr_inc : tr_count;
  end

  assign tr_m1 = (pair == '0) ? '0 : sat_cnt(quo + DIVW'(1));

  // Capture item on acceptance
  always_ff @(posedge clk) begin
    if (accept) begin
      itm_op    <= operation;
      itm_now   <= now_ms;
      itm_bv    <= byte_valid;
      itm_byte  <= rx_byte;
      itm_pulse <= pulse_count;
    end
  end

  // Working registers for simulated mode
  always_ff @(posedge clk) begin
    if (cmd.m0_e)      elapsed <= itm_now - scan_origin;
    if (cmd.latch_sl)  sl_sat  <= sat_cnt(quo);
    if (cmd.m0_commit) prod    <= stc_pkg::TIME_W'((quo[stc_pkg::TIME_W-1:0] - 32'd1) *
                                                   32'(len_eff));
  end

  // Counter and origin updates
  always_ff @(posedge clk) begin
    if (rst) begin
      tr_count    <= '0;
      slice_count <= '0;
      scan_origin <= '0;
      tr_origin   <= '0;
      last_pulse  <= '0;
      held_byte   <= '0;
      hb_wait     <= 1'b0;
      counting    <= 1'b0;
    end else begin
      if (cmd.start) begin
        tr_count    <= '0;
        slice_count <= '0;
        tr_origin   <= itm_now;
        scan_origin <= itm_now;
        counting    <= 1'b1;
        hb_wait     <= 1'b0;
        last_pulse  <= itm_pulse;
      end
      if (cmd.m0_prep && tr_count == '0) begin
        scan_origin <= itm_now - 32'd1;
        tr_origin   <= itm_now - 32'd1;
      end
      if (cmd.m0_commit) begin
        slice_count <= sl_sat;
        tr_count    <= sat_cnt(quo);
      end
      if (cmd.m0_org) tr_origin <= prod + scan_origin;
      if (cmd.simple) begin
        tr_count <= tr_simple;
        if (cfg.mode == stc_pkg::MODE_SLICE && itm_bv) begin
          held_byte <= itm_byte;
          hb_wait   <= 1'b1;
        end
        if (trig_simple && cfg.mode == stc_pkg::MODE_PULSE) last_pulse <= itm_pulse;
        if (tr_simple == '0) begin
          scan_origin <= itm_now;
          tr_origin   <= itm_now;
        end else if (trig_simple) begin
          tr_origin <= itm_now;
        end
      end
      if (cmd.m1_commit) begin
        hb_wait     <= 1'b0;
        slice_count <= sat_cnt(DIVW'(pair));
        tr_count    <= tr_m1;
        if (tr_m1 == '0) begin
          scan_origin <= itm_now;
          tr_origin   <= itm_now;
        end else if (pair != '0 && rem == '0) begin
          tr_origin <= itm_now;
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.write_out) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write_out) begin
      tr_number       <= stc_pkg::OUTC_W'(32'(tr_count));
      slice_number    <= stc_pkg::OUTC_W'(32'(slice_count));
      tr_start_time   <= tr_origin;
      scan_start_time <= scan_origin;
      is_counting     <= counting;
    end
  end

  assign status.op       = itm_op;
  assign status.counting = counting;
  assign status.mode     = cfg.mode;
  assign status.bv       = itm_bv;
  assign status.hb_wait  = hb_wait;
  assign status.div_done = div_done;
  assign status.out_free = !res_valid || res_ready;

endmodule

`default_nettype wire

// ===== design/stc_ctrl.sv =====
// Controller state machine: sequences each item through the datapath.
// Depends on stc_pkg.
`default_nettype none

module stc_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          item_valid,
  output logic               item_ready,
  input  stc_pkg::status_t   status,
  output stc_pkg::cmd_t      cmd
);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_DISPATCH = 10'b0000000010,
    S_M0_E     = 10'b0000000100,
    S_SL_GO    = 10'b0000001000,
    S_SL_WAIT  = 10'b0000010000,
    S_TR_GO    = 10'b0000100000,
    S_TR_WAIT  = 10'b0001000000,
    S_M0_ORG   = 10'b0010000000,
    S_M1_WAIT  = 10'b0100000000,
    S_WRITE    = 10'b1000000000
  } state_t;

  state_t state, state_next;

  assign item_ready = (state == S_IDLE);

  // Advance state
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // Next state and commands
  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.div_sel = stc_pkg::DIV_SL;
    case (state)
      S_IDLE: begin
        if (item_valid) state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        if (status.op) begin
          cmd.start  = 1'b1;
          state_next = S_WRITE;
        end else if (!status.counting) begin
          state_next = S_WRITE;
        end else if (status.mode == stc_pkg::MODE_SIM) begin
          cmd.m0_prep = 1'b1;
          state_next  = S_M0_E;
        end else if (status.mode == stc_pkg::MODE_SLICE && status.bv && status.hb_wait) begin
          cmd.div_go  = 1'b1;
          cmd.div_sel = stc_pkg::DIV_M1;
          state_next  = S_M1_WAIT;
        end else begin
          cmd.simple = 1'b1;
          state_next = S_WRITE;
        end
      end
      S_M0_E: begin
        cmd.m0_e   = 1'b1;
        state_next = S_SL_GO;
      end
      S_SL_GO: begin
        cmd.div_go  = 1'b1;
        cmd.div_sel = stc_pkg::DIV_SL;
        state_next  = S_SL_WAIT;
      end
      S_SL_WAIT: begin
        if (status.div_done) begin
          cmd.latch_sl = 1'b1;
          state_next   = S_TR_GO;
        end
      end
      S_TR_GO: begin
        cmd.div_go  = 1'b1;
        cmd.div_sel = stc_pkg::DIV_TR;
        state_next  = S_TR_WAIT;
      end
      S_TR_WAIT: begin
        if (status.div_done) begin
          cmd.m0_commit = 1'b1;
          state_next    = S_M0_ORG;
        end
      end
      S_M0_ORG: begin
        cmd.m0_org = 1'b1;
        state_next = S_WRITE;
      end
      S_M1_WAIT: begin
        cmd.div_sel = stc_pkg::DIV_M1;
        if (status.div_done) begin
          cmd.m1_commit = 1'b1;
          state_next    = S_WRITE;
        end
      end
      S_WRITE: begin
        if (status.out_free) begin
          cmd.write_out = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== design/scan_trigger_counter_unit.sv =====
// Scan trigger counter: one result transaction per input transaction.
// Start, idle polls and modes 2/3 go straight to the result; slice-number pairs and
// simulated mode use the one-bit-per-cycle 41-bit divider.
// Throughput: one item at a time; the next is taken once the result is in the
// output register. Synchronous reset clears counts, origins and config registers to defaults.
`default_nettype none

module scan_trigger_counter_unit #(
  parameter int COUNT_WIDTH = stc_pkg::COUNT_WIDTH_DEF,
  parameter int PULSE_WIDTH = stc_pkg::PULSE_WIDTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  stc_item_if.sink                         item,
  stc_result_if.source                     result,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [stc_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [stc_pkg::DATA_W-1:0]  pwdata,
  output logic      [stc_pkg::DATA_W-1:0]  prdata,
  output logic                             pready
);

  stc_pkg::cfg_t    cfg;
  stc_pkg::cmd_t    cmd;
  stc_pkg::status_t status;
  logic             accept;

  assign accept = item.valid && item.ready;

  stc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  stc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (item.ready),
    .status     (status),
    .cmd        (cmd)
  );

  stc_dp #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .PULSE_WIDTH (PULSE_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .accept          (accept),
    .operation       (item.operation),
    .now_ms          (item.now_ms),
    .byte_valid      (item.byte_valid),
    .rx_byte         (item.rx_byte),
    .pulse_count     (PULSE_WIDTH'(item.pulse_count)),
    .cmd             (cmd),
    .status          (status),
    .res_valid       (result.valid),
    .res_ready       (result.ready),
    .tr_number       (result.tr_number),
    .slice_number    (result.slice_number),
    .tr_start_time   (result.tr_start_time),
    .scan_start_time (result.scan_start_time),
    .is_counting     (result.is_counting)
  );

endmodule

`default_nettype wire
